// ===== design/lmss_pkg.sv =====
// ----------------------------------------------------------------------------
// lmss_pkg
// Shared types, constants and the fixed 5x7 font table of the scroll scanner.
// ----------------------------------------------------------------------------
package lmss_pkg;

  // Display geometry.
  localparam int GLYPH_COUNT    = 13;
  localparam int VISIBLE_GLYPHS = 6;
  localparam int ROW_COUNT      = 7;

  // Font table geometry and field widths.
  localparam int FONT_W     = 5;
  localparam int ROM_GLYPHS = 13;
  localparam int ROM_ROWS   = 7;
  localparam int ROM_DEPTH  = ROM_GLYPHS * ROM_ROWS;
  localparam int ROM_AW     = $clog2(ROM_DEPTH);
  localparam int GLYPH_IW   = $clog2(GLYPH_COUNT);
  localparam int ROW_W      = 3;
  localparam int LINES_W    = 8;
  localparam int COL_W      = (VISIBLE_GLYPHS - 1) * (FONT_W + 1);
  localparam int FULL_W     = COL_W + FONT_W;
  localparam int OFF_W      = 3;
  localparam int POS_W      = 4;
  localparam int CNT_W      = 8;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [FONT_W-1:0] BLANK_ROW  = 5'h1F;
  localparam logic [POS_W-1:0]  BOUNCE_TOP = 4'd8;

  // Reported mode codes.
  localparam logic [MODE_W-1:0] MODE_SCROLL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BOUNCE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PAUSE  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_SCROLL_STEP     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_BOUNCE_STEP     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_STEPS_BEFORE_BOUNCE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_FRAMES               = 8'd3;

  typedef struct packed {
    logic [CNT_W-1:0] frames_per_scroll_step;
    logic [CNT_W-1:0] frames_per_bounce_step;
    logic [CNT_W-1:0] scroll_steps_before_bounce;
    logic [CNT_W-1:0] pause_frames;
  } lmss_cfg_t;

  // State of the sequencer that the result is formed from.
  typedef struct packed {
    logic [ROW_W-1:0]    row_index;
    logic [OFF_W-1:0]    sub_offset;
    logic [GLYPH_IW-1:0] first_glyph;
    logic [POS_W-1:0]    bounce_pos;
    logic [MODE_W-1:0]   mode;
  } lmss_view_t;

  // Glyph-major font table, one 5-bit row per entry, 0 lights the LED.
  localparam logic [FONT_W-1:0] FONT_ROM [ROM_DEPTH] = '{
    5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F,
    5'h0E, 5'h0E, 5'h0E, 5'h0E, 5'h0A, 5'h04, 5'h0E,
    5'h0E, 5'h0E, 5'h0E, 5'h00, 5'h0E, 5'h0E, 5'h11,
    5'h0E, 5'h0E, 5'h0C, 5'h0A, 5'h06, 5'h0E, 5'h0E,
    5'h11, 5'h0E, 5'h0E, 5'h0E, 5'h0E, 5'h0E, 5'h0E,
    5'h0E, 5'h0E, 5'h0E, 5'h00, 5'h0E, 5'h0E, 5'h11,
    5'h00, 5'h0F, 5'h0F, 5'h0F, 5'h0F, 5'h0F, 5'h0F,
    5'h00, 5'h1B, 5'h1B, 5'h1B, 5'h1B, 5'h1B, 5'h00,
    5'h01, 5'h16, 5'h16, 5'h16, 5'h16, 5'h16, 5'h01,
    5'h0E, 5'h0E, 5'h0E, 5'h00, 5'h0E, 5'h0E, 5'h11,
    5'h01, 5'h16, 5'h16, 5'h16, 5'h16, 5'h16, 5'h01,
    5'h00, 5'h0F, 5'h0F, 5'h03, 5'h0F, 5'h0F, 5'h00,
    5'h01, 5'h1E, 5'h1E, 5'h11, 5'h0F, 5'h0F, 5'h10
  };

  // Rows or glyphs outside the table read as blank.
  function automatic logic [FONT_W-1:0] font_row(input logic [GLYPH_IW-1:0] g,
                                                 input logic [ROW_W-1:0] r);
    logic [ROM_AW-1:0] addr;
    addr = ROM_AW'(g) * ROM_AW'(ROM_ROWS) + ROM_AW'(r);
    if ((32'(g) >= ROM_GLYPHS) || (32'(r) >= ROM_ROWS)) begin
      return BLANK_ROW;
    end
    return FONT_ROM[addr];
  endfunction

endpackage

// ===== design/lmss_in_if.sv =====
// ----------------------------------------------------------------------------
// lmss_in_if
// Tick channel: one transaction per row period request.
// ----------------------------------------------------------------------------
interface lmss_in_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink (input valid, input advance, output ready);
endinterface

// ===== design/lmss_out_if.sv =====
// ----------------------------------------------------------------------------
// lmss_out_if
// Result channel: row drive lines, column bits and status of one row period.
// ----------------------------------------------------------------------------
interface lmss_out_if;
  logic                                valid;
  logic                                ready;
  logic [lmss_pkg::LINES_W-1:0]        row_lines;
  logic [lmss_pkg::COL_W-1:0]          column_bits;
  logic                                frame_start;
  logic [lmss_pkg::MODE_W-1:0]         mode_now;

  modport source (output valid, output row_lines, output column_bits,
                  output frame_start, output mode_now, input ready);
  modport sink (input valid, input row_lines, input column_bits,
                input frame_start, input mode_now, output ready);
endinterface

// ===== design/lmss_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lmss_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lmss_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lmss_pkg::CFG_IDX_W-1:0]    index;
  logic [lmss_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/led_matrix_scroll_scanner.sv =====
// ----------------------------------------------------------------------------
// led_matrix_scroll_scanner
// Row scanner for a 7-row, six-glyph scrolling LED dot-matrix display.
// ----------------------------------------------------------------------------
// Each tick transaction asks for one row period and returns one result
// transaction with the row drive lines, the 30 column bits (msb first, 0 lights
// the LED), a frame start flag and the current mode. A tick is taken every
// cycle unless stalled: the result is formed in one pass from the sequencer
// counters and the font table and lands in a single output register when the
// tick is taken, and a new tick is taken in the same cycle that a waiting
// result is taken. advance = 0 repeats the current row without moving any
// counter. Configuration writes, taken in every cycle, belong to idle periods.
module led_matrix_scroll_scanner (
  input  logic        clk,
  input  logic        rst,
  lmss_in_if.sink     tick,
  lmss_out_if.source  result,
  lmss_cfg_if.sink    cfg
);

  lmss_pkg::lmss_cfg_t          regs;
  lmss_pkg::lmss_view_t         view;
  logic [lmss_pkg::COL_W-1:0]   cols;
  logic [lmss_pkg::LINES_W-1:0] lines;
  logic                         accept;
  logic                         out_valid;

  assign tick.ready = !out_valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  lmss_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lmss_sequencer u_sequencer (
    .clk     (clk),
    .rst     (rst),
    .step_en (accept && tick.advance),
    .regs    (regs),
    .view    (view)
  );

  lmss_columns u_columns (
    .view        (view),
    .column_bits (cols)
  );

  // Bounce shifts the row line up; bits past the top are lost.
  always_comb begin
    lines = 8'd1 << view.row_index;
    if (view.mode == lmss_pkg::MODE_BOUNCE) begin
      lines = lines << view.bounce_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.row_lines   <= lines;
      result.column_bits <= cols;
      result.frame_start <= (view.row_index == '0);
      result.mode_now    <= view.mode;
    end
  end

  assign result.valid = out_valid;

endmodule

// ===== design/lmss_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lmss_cfg_regs
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module lmss_cfg_regs (
  input  logic                 clk,
  input  logic                 rst,
  lmss_cfg_if.sink             cfg,
  output lmss_pkg::lmss_cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.frames_per_scroll_step     <= 8'd8;
      regs.frames_per_bounce_step     <= 8'd20;
      regs.scroll_steps_before_bounce <= 8'd80;
      regs.pause_frames               <= 8'd199;
    end else if (cfg.valid) begin
      case (cfg.index)
        lmss_pkg::CFG_FRAMES_PER_SCROLL_STEP:     regs.frames_per_scroll_step <= cfg.data;
        lmss_pkg::CFG_FRAMES_PER_BOUNCE_STEP:     regs.frames_per_bounce_step <= cfg.data;
        lmss_pkg::CFG_SCROLL_STEPS_BEFORE_BOUNCE: regs.scroll_steps_before_bounce <= cfg.data;
        lmss_pkg::CFG_PAUSE_FRAMES:               regs.pause_frames <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/lmss_sequencer.sv =====
// ----------------------------------------------------------------------------
// lmss_sequencer
// Row, frame, scroll, bounce and pause counters of the scanner.
// ----------------------------------------------------------------------------
module lmss_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step_en,
  input  lmss_pkg::lmss_cfg_t  regs,
  output lmss_pkg::lmss_view_t view
);

  logic [lmss_pkg::ROW_W-1:0]    row_index, row_index_next;
  logic [lmss_pkg::CNT_W-1:0]    frame_count, frame_count_next;
  logic [lmss_pkg::OFF_W-1:0]    sub_offset, sub_offset_next;
  logic [lmss_pkg::GLYPH_IW-1:0] first_glyph, first_glyph_next;
  logic [lmss_pkg::CNT_W-1:0]    step_count, step_count_next;
  logic [lmss_pkg::POS_W-1:0]    bounce_pos, bounce_pos_next;
  logic                          bounce_down, bounce_down_next;
  logic                          mode_reg, mode_reg_next;  // 1 means bounce
  logic [lmss_pkg::CNT_W-1:0]    pause_count, pause_count_next;

  logic [lmss_pkg::CNT_W-1:0]    need;
  logic [lmss_pkg::CNT_W-1:0]    frame_inc;
  logic [lmss_pkg::OFF_W:0]      off_inc;
  logic [lmss_pkg::GLYPH_IW:0]   glyph_inc;
  logic [lmss_pkg::CNT_W-1:0]    step_inc;
  logic [lmss_pkg::POS_W-1:0]    pos_move;
  logic                          last_row;

  always_comb begin
    row_index_next   = row_index;
    frame_count_next = frame_count;
    sub_offset_next  = sub_offset;
    first_glyph_next = first_glyph;
    step_count_next  = step_count;
    bounce_pos_next  = bounce_pos;
    bounce_down_next = bounce_down;
    mode_reg_next    = mode_reg;
    pause_count_next = pause_count;

    last_row  = (({1'b0, row_index} + 4'd1) >= 4'(lmss_pkg::ROW_COUNT));
    need      = mode_reg ? regs.frames_per_bounce_step : regs.frames_per_scroll_step;
    if (need == '0) begin
      need = 8'd1;
    end
    frame_inc = frame_count + 8'd1;
    off_inc   = {1'b0, sub_offset} + 4'd1;
    glyph_inc = {1'b0, first_glyph} + 5'd1;
    if (glyph_inc >= 5'(lmss_pkg::GLYPH_COUNT)) begin
      glyph_inc = glyph_inc - 5'(lmss_pkg::GLYPH_COUNT);
    end
    step_inc  = step_count + 8'd1;
    pos_move  = bounce_down ? (bounce_pos - 4'd1) : (bounce_pos + 4'd1);

    if (step_en) begin
      if (!last_row) begin
        row_index_next = row_index + 3'd1;
      end else begin
        row_index_next = '0;
        // End of frame: a pause only counts down and freezes everything else.
        if (pause_count != '0) begin
          pause_count_next = pause_count - 8'd1;
        end else if (frame_inc < need) begin
          frame_count_next = frame_inc;
        end else begin
          frame_count_next = '0;
          if (mode_reg) begin
            bounce_pos_next = pos_move;
            if (pos_move >= lmss_pkg::BOUNCE_TOP) begin
              bounce_down_next = 1'b1;
            end
            if ((bounce_down || (pos_move >= lmss_pkg::BOUNCE_TOP)) &&
                (pos_move == '0)) begin
              bounce_down_next = 1'b0;
              mode_reg_next    = 1'b0;
              pause_count_next = regs.pause_frames;
            end
          end else begin
            if (off_inc > 4'(lmss_pkg::FONT_W)) begin
              sub_offset_next  = '0;
              first_glyph_next = glyph_inc[lmss_pkg::GLYPH_IW-1:0];
            end else begin
              sub_offset_next  = off_inc[lmss_pkg::OFF_W-1:0];
            end
            if (step_inc >= regs.scroll_steps_before_bounce) begin
              step_count_next  = '0;
              mode_reg_next    = 1'b1;
              pause_count_next = regs.pause_frames;
            end else begin
              step_count_next  = step_inc;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index   <= '0;
      frame_count <= '0;
      sub_offset  <= '0;
      first_glyph <= '0;
      step_count  <= '0;
      bounce_pos  <= 4'd1;
      bounce_down <= 1'b0;
      mode_reg    <= 1'b0;
      pause_count <= '0;
    end else begin
      row_index   <= row_index_next;
      frame_count <= frame_count_next;
      sub_offset  <= sub_offset_next;
      first_glyph <= first_glyph_next;
      step_count  <= step_count_next;
      bounce_pos  <= bounce_pos_next;
      bounce_down <= bounce_down_next;
      mode_reg    <= mode_reg_next;
      pause_count <= pause_count_next;
    end
  end

  always_comb begin
    view.row_index   = row_index;
    view.sub_offset  = sub_offset;
    view.first_glyph = first_glyph;
    view.bounce_pos  = bounce_pos;
    if (pause_count != '0) begin
      view.mode = lmss_pkg::MODE_PAUSE;
    end else if (mode_reg) begin
      view.mode = lmss_pkg::MODE_BOUNCE;
    end else begin
      view.mode = lmss_pkg::MODE_SCROLL;
    end
  end

endmodule

// ===== design/lmss_columns.sv =====
// ----------------------------------------------------------------------------
// lmss_columns
// Builds the column bits of one row from the font table and the scroll offset.
// ----------------------------------------------------------------------------
module lmss_columns (
  input  lmss_pkg::lmss_view_t        view,
  output logic [lmss_pkg::COL_W-1:0]  column_bits
);

  logic [lmss_pkg::FULL_W-1:0] full;
  logic [lmss_pkg::OFF_W-1:0]  off;
  logic [lmss_pkg::OFF_W-1:0]  drop;
  logic [lmss_pkg::GLYPH_IW:0] gsum;

  // All six glyph rows with separators go into one word; the visible window
  // drops the leading offset bits of the first glyph and the unseen tail of
  // the last glyph.
  always_comb begin
    full = '0;
    for (int i = 0; i < lmss_pkg::VISIBLE_GLYPHS; i++) begin
      gsum = {1'b0, view.first_glyph} + (lmss_pkg::GLYPH_IW + 1)'(i);
      if (gsum >= (lmss_pkg::GLYPH_IW + 1)'(lmss_pkg::GLYPH_COUNT)) begin
        gsum = gsum - (lmss_pkg::GLYPH_IW + 1)'(lmss_pkg::GLYPH_COUNT);
      end
      full[lmss_pkg::FULL_W - 1 - i * (lmss_pkg::FONT_W + 1) -: lmss_pkg::FONT_W] =
        lmss_pkg::font_row(gsum[lmss_pkg::GLYPH_IW-1:0], view.row_index);
      if (i < lmss_pkg::VISIBLE_GLYPHS - 1) begin
        full[lmss_pkg::FULL_W - 1 - i * (lmss_pkg::FONT_W + 1) - lmss_pkg::FONT_W] = 1'b1;
      end
    end
    off = (view.sub_offset > 3'(lmss_pkg::FONT_W)) ? 3'(lmss_pkg::FONT_W)
                                                   : view.sub_offset;
    drop = 3'(lmss_pkg::FONT_W) - off;
    column_bits = lmss_pkg::COL_W'(full >> drop);
  end

endmodule
